/* design/vdte_pkg.sv */
`default_nettype none
// ============================================================================
// vdte_pkg
// Shared types and constants of the dual triangle extractor.
// ============================================================================
package vdte_pkg;

    localparam int VERTEX_W = 16;
    localparam int LABEL_W  = 12;
    localparam int SLOT_W   = 12;
    localparam int SET_SLOTS = 1 << SLOT_W;
    localparam int COUNT_W  = SLOT_W + 1;
    localparam int KEY_W    = 3 * LABEL_W;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_FACE  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_DONE = 3'd0,
        ST_SKIP = 3'd1,
        ST_DUP  = 3'd2,
        ST_NEW  = 3'd3,
        ST_FULL = 3'd4
    } status_t;

    typedef struct packed {
        req_t                 req;
        logic [VERTEX_W-1:0]  va;
        logic [VERTEX_W-1:0]  vb;
        logic [VERTEX_W-1:0]  vc;
        logic [LABEL_W-1:0]   label;
    } cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE, BK_RDA, BK_RDB, BK_RDC, BK_CANON, BK_HASH, BK_HASH2,
        BK_PROBE, BK_CMP, BK_CLEAR, BK_OUT, BK_INIT
    } bk_state_t;

endpackage : vdte_pkg
`default_nettype wire

/* design/vdte_cmd_fifo.sv */
`default_nettype none
// ============================================================================
// vdte_cmd_fifo
// Two-entry request queue between the input port and the execution engine.
// ============================================================================
module vdte_cmd_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  vdte_pkg::cmd_t     wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output vdte_pkg::cmd_t     rd_data
);
    import vdte_pkg::*;

    cmd_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wptr_reg] <= wr_data;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (do_wr) wptr_reg <= !wptr_reg;
            if (do_rd) rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !do_wr) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !do_rd) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");

endmodule : vdte_cmd_fifo
`default_nettype wire

/* design/vdte_engine.sv */
`default_nettype none
// ============================================================================
// vdte_engine
// Label table, triangle set with linear probing, and the result register.
// ============================================================================
module vdte_engine (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cmd_valid,
    output logic                           cmd_ready,
    input  vdte_pkg::cmd_t                 cmd,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [2:0]                     m_status,
    output logic [vdte_pkg::LABEL_W-1:0]   m_tri_first,
    output logic [vdte_pkg::LABEL_W-1:0]   m_tri_second,
    output logic [vdte_pkg::LABEL_W-1:0]   m_tri_third,
    output logic [vdte_pkg::COUNT_W-1:0]   m_tri_count
);
    import vdte_pkg::*;

    localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;

    logic [LABEL_W-1:0]  label_mem [1 << VERTEX_W];
    logic [KEY_W:0]      tri_mem [SET_SLOTS];

    bk_state_t state_reg, state_next;
    cmd_t      cmd_reg;
    logic [LABEL_W-1:0] la_reg, lb_reg, lrd_reg;
    logic [LABEL_W-1:0] f_reg, s_reg, t_reg;
    logic [SLOT_W-1:0]  pos_reg;
    logic [SLOT_W-1:0]  clr_ptr_reg;
    logic [SLOT_W:0]    tries_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [KEY_W:0]     slot_rd_reg;
    logic               slot_vld;
    logic [KEY_W-1:0]   slot_key;
    logic [63:0]        prod_lo_reg, prod_hi_reg;
    logic [2:0]         status_reg;
    logic               out_valid_reg;
    logic [VERTEX_W-1:0] rd_addr;
    logic [KEY_W-1:0]    key;
    logic [63:0]         h;
    logic                distinct;
    logic                clearing;

    assign key = {f_reg, s_reg, t_reg};
    assign h = prod_lo_reg + (prod_hi_reg << 32);
    assign distinct = (la_reg != lb_reg) && (lb_reg != lrd_reg) && (lrd_reg != la_reg);
    assign slot_vld = slot_rd_reg[KEY_W];
    assign slot_key = slot_rd_reg[KEY_W-1:0];
    assign clearing = (state_reg == BK_INIT) || (state_reg == BK_CLEAR);

    always_comb begin
        unique case (state_reg)
            BK_RDA:  rd_addr = cmd_reg.va;
            BK_RDB:  rd_addr = cmd_reg.vb;
            default: rd_addr = cmd_reg.vc;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_INIT: if (clr_ptr_reg == SLOT_W'(SET_SLOTS - 1)) state_next = BK_IDLE;
            BK_IDLE: if (cmd_valid) state_next = BK_RDA;
            BK_RDA: begin
                unique case (cmd_reg.req)
                    REQ_FACE:  state_next = BK_RDB;
                    REQ_CLEAR: state_next = BK_CLEAR;
                    default:   state_next = BK_OUT;
                endcase
            end
            BK_RDB:   state_next = BK_RDC;
            BK_RDC:   state_next = BK_CANON;
            BK_CANON: state_next = distinct ? BK_HASH : BK_OUT;
            BK_HASH:  state_next = BK_HASH2;
            BK_HASH2: state_next = BK_PROBE;
            BK_PROBE: state_next = BK_CMP;
            BK_CMP: begin
                if (!slot_vld || slot_key == key) begin
                    state_next = BK_OUT;
                end else if (tries_reg == (SLOT_W+1)'(SET_SLOTS - 1)) begin
                    state_next = BK_OUT;
                end else begin
                    state_next = BK_PROBE;
                end
            end
            BK_CLEAR: if (clr_ptr_reg == SLOT_W'(SET_SLOTS - 1)) state_next = BK_OUT;
            BK_OUT:   if (!out_valid_reg || m_ready) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        cmd_ready = (state_reg == BK_IDLE);
    end

    always_ff @(posedge aclk) begin
        lrd_reg <= label_mem[rd_addr];
        if (state_reg == BK_RDA && cmd_reg.req == REQ_LOAD) begin
            label_mem[cmd_reg.va] <= cmd_reg.label;
        end
        slot_rd_reg <= tri_mem[pos_reg];
        if (clearing) begin
            tri_mem[clr_ptr_reg] <= '0;
        end else if (state_reg == BK_CMP && !slot_vld && count_reg < COUNT_W'(SET_SLOTS)) begin
            tri_mem[pos_reg] <= {1'b1, key};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_INIT;
            clr_ptr_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) clr_ptr_reg <= clr_ptr_reg + 1'b1;
            if (state_reg == BK_IDLE && cmd_valid) cmd_reg <= cmd;
            if (state_reg == BK_RDA) begin
                status_reg <= ST_DONE;
                f_reg <= '0; s_reg <= '0; t_reg <= '0;
                if (cmd_reg.req == REQ_CLEAR) begin
                    count_reg <= '0;
                end
            end
            if (state_reg == BK_RDB) la_reg <= lrd_reg;
            if (state_reg == BK_RDC) lb_reg <= lrd_reg;
            if (state_reg == BK_CANON) begin
                if (!distinct) begin
                    status_reg <= ST_SKIP;
                end else if (lb_reg < la_reg && lb_reg < lrd_reg) begin
                    f_reg <= lb_reg; s_reg <= lrd_reg; t_reg <= la_reg;
                end else if (lrd_reg < la_reg && lrd_reg < lb_reg) begin
                    f_reg <= lrd_reg; s_reg <= la_reg; t_reg <= lb_reg;
                end else begin
                    f_reg <= la_reg; s_reg <= lb_reg; t_reg <= lrd_reg;
                end
            end
            if (state_reg == BK_HASH) begin
                prod_lo_reg <= {28'd0, key} * GOLDEN[31:0];
                prod_hi_reg <= {28'd0, key} * GOLDEN[63:32];
            end
            if (state_reg == BK_HASH2) begin
                pos_reg   <= SLOT_W'(h ^ (h >> 29));
                tries_reg <= '0;
            end
            if (state_reg == BK_CMP) begin
                if (!slot_vld) begin
                    if (count_reg >= COUNT_W'(SET_SLOTS)) begin
                        status_reg <= ST_FULL;
                    end else begin
                        count_reg <= count_reg + 1'b1;
                        status_reg <= ST_NEW;
                    end
                end else if (slot_key == key) begin
                    status_reg <= ST_DUP;
                end else begin
                    status_reg <= ST_FULL;
                    pos_reg    <= pos_reg + 1'b1;
                    tries_reg  <= tries_reg + 1'b1;
                end
            end
            if (state_reg == BK_OUT && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
                m_status      <= status_reg;
                m_tri_first   <= f_reg;
                m_tri_second  <= s_reg;
                m_tri_third   <= t_reg;
                m_tri_count   <= count_reg;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(SET_SLOTS)) else $error("count exceeds set size");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_ready |-> state_reg == BK_IDLE) else $error("ready outside idle");
    a_new_bumps: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_CMP && !slot_vld && count_reg < COUNT_W'(SET_SLOTS)
        |=> count_reg == $past(count_reg) + 1'b1) else $error("count not advanced");

endmodule : vdte_engine
`default_nettype wire

/* design/voronoi_dual_triangle_extract.sv */
`default_nettype none
// ============================================================================
// voronoi_dual_triangle_extract
// Maps face vertices to region labels and collects distinct label triangles.
// ============================================================================
// Channel | Direction | Content
// s_      | in        | req_type, vertex_a/b/c, region_label
// m_      | out       | status, tri_first/second/third, tri_count
//
// A beat accepted into the queue is registered there before the engine takes
// it. The engine holds a load or unknown request until it writes its result,
// a skipped face until its labels are read and compared, and a probed face
// through label reads, ordering, hashing and each probe of the set. A clear
// request walks all 4096 set slots; the same pass runs after reset before the
// first request is served. A result held at the output stalls the next one;
// the two-entry queue fills meanwhile. Labels are undefined until loaded.
module voronoi_dual_triangle_extract (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_req_type,
    input  wire logic [vdte_pkg::VERTEX_W-1:0] s_vertex_a,
    input  wire logic [vdte_pkg::VERTEX_W-1:0] s_vertex_b,
    input  wire logic [vdte_pkg::VERTEX_W-1:0] s_vertex_c,
    input  wire logic [vdte_pkg::LABEL_W-1:0]  s_region_label,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [2:0]                         m_status,
    output logic [vdte_pkg::LABEL_W-1:0]       m_tri_first,
    output logic [vdte_pkg::LABEL_W-1:0]       m_tri_second,
    output logic [vdte_pkg::LABEL_W-1:0]       m_tri_third,
    output logic [vdte_pkg::COUNT_W-1:0]       m_tri_count
);
    import vdte_pkg::*;

    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;

    assign in_cmd = '{req: req_t'(s_req_type), va: s_vertex_a, vb: s_vertex_b,
                      vc: s_vertex_c, label: s_region_label};

    vdte_cmd_fifo u_fifo (
        .aclk, .aresetn,
        .wr_valid(s_valid), .wr_ready(s_ready), .wr_data(in_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    vdte_engine u_engine (
        .aclk, .aresetn,
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .m_valid, .m_ready, .m_status, .m_tri_first, .m_tri_second,
        .m_tri_third, .m_tri_count
    );

endmodule : voronoi_dual_triangle_extract
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the dual triangle extractor. It drives directed
// rows, a pass of faces over a small label set in both orientations, and
// random label loads, faces, clears and unknown requests. Directed rows carry
// expected results; other beats are predicted by a local label and set model.
// ============================================================================
module tb;
    import vdte_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int RAND_ITEMS  = 1150;
    localparam int QUIET_ITEMS = 200;
    localparam int FILL_LABELS = 8;

    typedef struct {
        logic [2:0]         st;
        logic [LABEL_W-1:0] f;
        logic [LABEL_W-1:0] s;
        logic [LABEL_W-1:0] t;
        logic [COUNT_W-1:0] cnt;
    } tri_result_t;

    typedef struct {
        req_t                req;
        logic [VERTEX_W-1:0] va;
        logic [VERTEX_W-1:0] vb;
        logic [VERTEX_W-1:0] vc;
        logic [LABEL_W-1:0]  label;
        bit                  typed;
        tri_result_t         res;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_req_type = 2'd0;
    logic [VERTEX_W-1:0] s_vertex_a = '0;
    logic [VERTEX_W-1:0] s_vertex_b = '0;
    logic [VERTEX_W-1:0] s_vertex_c = '0;
    logic [LABEL_W-1:0]  s_region_label = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [2:0]          m_status;
    logic [LABEL_W-1:0]  m_tri_first;
    logic [LABEL_W-1:0]  m_tri_second;
    logic [LABEL_W-1:0]  m_tri_third;
    logic [COUNT_W-1:0]  m_tri_count;

    logic [LABEL_W-1:0]  vertex_labels [1 << VERTEX_W];
    bit                  vertex_loaded [1 << VERTEX_W];
    logic [VERTEX_W-1:0] loaded_vertices [$];
    logic [KEY_W-1:0]    set_keys [SET_SLOTS];
    bit                  set_used [SET_SLOTS];
    int                  set_count;
    tri_result_t         pending_results [$];
    dir_row_t            dir_rows [14];
    bit                  quiet;
    bit                  failed;
    int                  cycle_count;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    voronoi_dual_triangle_extract i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_vertex_a     (s_vertex_a),
        .s_vertex_b     (s_vertex_b),
        .s_vertex_c     (s_vertex_c),
        .s_region_label (s_region_label),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_tri_first    (m_tri_first),
        .m_tri_second   (m_tri_second),
        .m_tri_third    (m_tri_third),
        .m_tri_count    (m_tri_count)
    );

    function automatic logic [SLOT_W-1:0] slot_of(input logic [KEY_W-1:0] key);
        logic [63:0] h;
        h = 64'(key) * 64'h9E3779B97F4A7C15;
        h = h ^ (h >> 29);
        return h[SLOT_W-1:0];
    endfunction

    function automatic tri_result_t extract_triangle(input req_t req,
            input logic [VERTEX_W-1:0] va, input logic [VERTEX_W-1:0] vb,
            input logic [VERTEX_W-1:0] vc, input logic [LABEL_W-1:0] label);
        tri_result_t r;
        logic [LABEL_W-1:0] a, b, c;
        logic [KEY_W-1:0] key;
        logic [SLOT_W-1:0] pos;
        r = '{ST_DONE, '0, '0, '0, '0};
        case (req)
            REQ_LOAD: begin
                vertex_labels[va] = label;
                if (!vertex_loaded[va]) begin
                    vertex_loaded[va] = 1'b1;
                    loaded_vertices.push_back(va);
                end
            end
            REQ_FACE: begin
                a = vertex_labels[va];
                b = vertex_labels[vb];
                c = vertex_labels[vc];
                if (a == b || b == c || c == a) begin
                    r.st = ST_SKIP;
                end else begin
                    if (b < a && b < c) begin
                        r.f = b; r.s = c; r.t = a;
                    end else if (c < a && c < b) begin
                        r.f = c; r.s = a; r.t = b;
                    end else begin
                        r.f = a; r.s = b; r.t = c;
                    end
                    key = {r.f, r.s, r.t};
                    pos = slot_of(key);
                    r.st = ST_FULL;
                    for (int n = 0; n < SET_SLOTS; n++) begin
                        if (!set_used[pos]) begin
                            if (set_count < SET_SLOTS) begin
                                set_used[pos] = 1'b1;
                                set_keys[pos] = key;
                                set_count++;
                                r.st = ST_NEW;
                            end
                            break;
                        end
                        if (set_keys[pos] == key) begin
                            r.st = ST_DUP;
                            break;
                        end
                        pos = pos + 1'b1;
                    end
                end
            end
            REQ_CLEAR: begin
                foreach (set_used[i]) set_used[i] = 1'b0;
                set_count = 0;
            end
            default: ;
        endcase
        r.cnt = COUNT_W'(set_count);
        return r;
    endfunction

    task automatic send_beat(input req_t req, input logic [VERTEX_W-1:0] va,
            input logic [VERTEX_W-1:0] vb, input logic [VERTEX_W-1:0] vc,
            input logic [LABEL_W-1:0] label, input bit typed,
            input tri_result_t typed_res);
        tri_result_t r;
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_vertex_a     <= va;
        s_vertex_b     <= vb;
        s_vertex_c     <= vc;
        s_region_label <= label;
        do @(posedge aclk); while (!s_ready);
        r = extract_triangle(req, va, vb, vc, label);
        pending_results.push_back(typed ? typed_res : r);
        @(negedge aclk);
        if (!quiet && $urandom_range(3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(negedge aclk);
        end
    endtask

    task automatic send_random();
        int sel;
        logic [VERTEX_W-1:0] va;
        logic [LABEL_W-1:0] label;
        tri_result_t none;
        none = '{ST_DONE, '0, '0, '0, '0};
        sel = $urandom_range(99);
        if (sel < 28) begin
            va = ($urandom_range(1) == 0)
                ? loaded_vertices[$urandom_range(loaded_vertices.size() - 1)]
                : VERTEX_W'($urandom);
            label = ($urandom_range(7) == 0) ? LABEL_W'($urandom)
                                             : LABEL_W'($urandom_range(15));
            send_beat(REQ_LOAD, va, VERTEX_W'($urandom), VERTEX_W'($urandom),
                      label, 1'b0, none);
        end else if (sel < 92) begin
            send_beat(REQ_FACE,
                      loaded_vertices[$urandom_range(loaded_vertices.size() - 1)],
                      loaded_vertices[$urandom_range(loaded_vertices.size() - 1)],
                      loaded_vertices[$urandom_range(loaded_vertices.size() - 1)],
                      LABEL_W'($urandom), 1'b0, none);
        end else if (sel < 95) begin
            send_beat(REQ_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom),
                      VERTEX_W'($urandom), LABEL_W'($urandom), 1'b0, none);
        end else begin
            send_beat(REQ_NOP, VERTEX_W'($urandom), VERTEX_W'($urandom),
                      VERTEX_W'($urandom), LABEL_W'($urandom), 1'b0, none);
        end
    endtask

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result beat, status %0d", m_status);
                    failed = 1'b1;
                end else begin
                    tri_result_t e;
                    e = pending_results.pop_front();
                    if (m_status !== e.st) begin
                        $error("status: expected %0d, got %0d", e.st, m_status);
                        failed = 1'b1;
                    end
                    if (m_tri_first !== e.f) begin
                        $error("tri_first: expected %0d, got %0d", e.f, m_tri_first);
                        failed = 1'b1;
                    end
                    if (m_tri_second !== e.s) begin
                        $error("tri_second: expected %0d, got %0d", e.s, m_tri_second);
                        failed = 1'b1;
                    end
                    if (m_tri_third !== e.t) begin
                        $error("tri_third: expected %0d, got %0d", e.t, m_tri_third);
                        failed = 1'b1;
                    end
                    if (m_tri_count !== e.cnt) begin
                        $error("tri_count: expected %0d, got %0d", e.cnt, m_tri_count);
                        failed = 1'b1;
                    end
                end
            end
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(3) == 0) begin
                stall = $urandom_range(5, 1) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int faces;
        tri_result_t none;
        none = '{ST_DONE, '0, '0, '0, '0};
        cycle_count = 0;
        failed = 1'b0;
        quiet = 1'b0;
        set_count = 0;
        foreach (set_used[i]) set_used[i] = 1'b0;
        foreach (vertex_loaded[i]) vertex_loaded[i] = 1'b0;
        foreach (vertex_labels[i]) vertex_labels[i] = '0;

        dir_rows[0]  = '{REQ_NOP, 16'h1234, 16'hFFFF, 16'h0000, 12'hFFF, 1,
                         '{ST_DONE, 0, 0, 0, 0}};
        dir_rows[1]  = '{REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 1,
                         '{ST_DONE, 0, 0, 0, 0}};
        dir_rows[2]  = '{REQ_LOAD, 16'h0000, 16'hFFFF, 16'hFFFF, 12'h000, 1,
                         '{ST_DONE, 0, 0, 0, 0}};
        dir_rows[3]  = '{REQ_LOAD, 16'hFFFF, 16'h0000, 16'h0000, 12'hFFF, 1,
                         '{ST_DONE, 0, 0, 0, 0}};
        dir_rows[4]  = '{REQ_LOAD, 16'h5555, 16'h0000, 16'h0000, 12'hAAA, 1,
                         '{ST_DONE, 0, 0, 0, 0}};
        dir_rows[5]  = '{REQ_LOAD, 16'hAAAA, 16'h0000, 16'h0000, 12'h555, 1,
                         '{ST_DONE, 0, 0, 0, 0}};
        dir_rows[6]  = '{REQ_FACE, 16'h0000, 16'hFFFF, 16'h5555, 12'h000, 1,
                         '{ST_NEW, 12'h000, 12'hFFF, 12'hAAA, 1}};
        dir_rows[7]  = '{REQ_FACE, 16'hFFFF, 16'h5555, 16'h0000, 12'hFFF, 1,
                         '{ST_DUP, 12'h000, 12'hFFF, 12'hAAA, 1}};
        dir_rows[8]  = '{REQ_FACE, 16'h0000, 16'h5555, 16'hFFFF, 12'h000, 1,
                         '{ST_NEW, 12'h000, 12'hAAA, 12'hFFF, 2}};
        dir_rows[9]  = '{REQ_FACE, 16'h0000, 16'h0000, 16'hFFFF, 12'h000, 1,
                         '{ST_SKIP, 0, 0, 0, 2}};
        dir_rows[10] = '{REQ_FACE, 16'h5555, 16'hAAAA, 16'hFFFF, 12'h000, 1,
                         '{ST_NEW, 12'h555, 12'hFFF, 12'hAAA, 3}};
        dir_rows[11] = '{REQ_NOP, 16'hAAAA, 16'h5555, 16'hFFFF, 12'h555, 1,
                         '{ST_DONE, 0, 0, 0, 3}};
        dir_rows[12] = '{REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000, 12'h000, 1,
                         '{ST_DONE, 0, 0, 0, 0}};
        dir_rows[13] = '{REQ_FACE, 16'hFFFF, 16'h5555, 16'h0000, 12'h000, 1,
                         '{ST_NEW, 12'h000, 12'hFFF, 12'hAAA, 1}};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].req, dir_rows[i].va, dir_rows[i].vb,
                      dir_rows[i].vc, dir_rows[i].label, dir_rows[i].typed,
                      dir_rows[i].res);
        end

        // Send every face over a small label set in both orientations.
        send_beat(REQ_CLEAR, '0, '0, '0, '0, 1'b0, none);
        for (int i = 0; i < FILL_LABELS; i++) begin
            send_beat(REQ_LOAD, VERTEX_W'(16'h0100 + i), '0, '0, LABEL_W'(i), 1'b0, none);
        end
        faces = 0;
        for (int a = 0; a < FILL_LABELS && faces < SET_SLOTS + 4; a++) begin
            for (int b = a + 1; b < FILL_LABELS && faces < SET_SLOTS + 4; b++) begin
                for (int c = b + 1; c < FILL_LABELS && faces < SET_SLOTS + 4; c++) begin
                    send_beat(REQ_FACE, VERTEX_W'(16'h0100 + a), VERTEX_W'(16'h0100 + b),
                              VERTEX_W'(16'h0100 + c), '0, 1'b0, none);
                    send_beat(REQ_FACE, VERTEX_W'(16'h0100 + b), VERTEX_W'(16'h0100 + a),
                              VERTEX_W'(16'h0100 + c), '0, 1'b0, none);
                    faces += 2;
                end
            end
        end
        send_beat(REQ_FACE, 16'h0100, 16'h0101, 16'h0102, '0, 1'b0, none);
        send_beat(REQ_CLEAR, '0, '0, '0, '0, 1'b0, none);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            send_random();
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (!failed) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
